FILE: sv/itrs_pkg.sv
// Package for the integer to radix string core: widths, character codes,
// controller/datapath command and status structs, digit-to-ASCII function.
// No dependencies.
package itrs_pkg;

   localparam int VALUE_W        = 63;
   localparam int BASE_W         = 6;
   localparam int CHAR_W         = 7;
   localparam int DIGIT_W        = 6;
   localparam int STEP_W         = 6;
   localparam int MAX_DIGITS_DEF = 64;

   localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2D);
   localparam logic [CHAR_W-1:0] CHAR_QUEST = CHAR_W'(8'h3F);
   localparam logic [CHAR_W-1:0] LETTER_OFS = CHAR_W'(17);
   localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request, clear counters
      logic step;        // one restoring division step
      logic store;       // write digit, start next division
      logic rd;          // read digit buffer at count-1
      logic emit_sign;   // load '-' into the output register
      logic emit_digit;  // load buffered digit, decrement count
      logic emit_bad;    // load '?' with bad_base
   } itrs_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic base_bad;    // request base outside 2..36
      logic step_last;   // final step of the current division
      logic quot_zero;   // quotient is zero
      logic cnt_top;     // buffer will be full after this store
      logic neg;         // value was negative
      logic idx_last;    // emitting the least significant digit
      logic out_free;    // output register can take a character
   } itrs_sts_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] r;
      if (d < DEC_DIGITS) begin
         r = CHAR_ZERO + CHAR_W'(d);
      end else begin
         r = CHAR_ZERO + LETTER_OFS + CHAR_W'(d - DEC_DIGITS);
      end
      return r;
   endfunction

endpackage

FILE: sv/itrs_ctrl.sv
// Controller for the integer to radix string core: sequences division,
// digit storage and character emission. Depends on itrs_pkg.
module itrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  itrs_pkg::itrs_sts_type sts,
   output itrs_pkg::itrs_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_STORE = 3'd2;
   localparam logic [2:0] S_SIGN = 3'd3;
   localparam logic [2:0] S_READ = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;
   localparam logic [2:0] S_BAD  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.base_bad ? S_BAD : S_DIV;
            end
         end
         S_DIV: begin
            cmd.step = 1'b1;
            if (sts.step_last) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            if (!sts.quot_zero && !sts.cnt_top) begin
               state_in = S_DIV;
            end else begin
               state_in = sts.neg ? S_SIGN : S_READ;
            end
         end
         S_SIGN: begin
            if (sts.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_digit = 1'b1;
               state_in       = sts.idx_last ? S_IDLE : S_READ;
            end
         end
         S_BAD: begin
            if (sts.out_free) begin
               cmd.emit_bad = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/itrs_dpath.sv
// Datapath for the integer to radix string core: bit-serial divider, digit
// buffer memory, digit count and output register. Depends on itrs_pkg.
module itrs_dpath #(
   parameter int MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [itrs_pkg::VALUE_W-1:0] req_value,
   input  logic        [itrs_pkg::BASE_W-1:0]  req_base,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [itrs_pkg::CHAR_W-1:0]  rsp_character,
   output logic                                rsp_last,
   output logic                                rsp_bad_base,
   input  itrs_pkg::itrs_cmd_type              cmd,
   output itrs_pkg::itrs_sts_type              sts
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int VW    = itrs_pkg::VALUE_W;
   localparam int BW    = itrs_pkg::BASE_W;
   localparam int DW    = itrs_pkg::DIGIT_W;
   localparam int CW    = itrs_pkg::CHAR_W;

   logic [DW-1:0] digit_mem [MAX_DIGITS];

   logic [VW-1:0]  mag_ff;
   logic [BW-1:0]  base_ff;
   logic [DW-1:0]  rem_ff;
   logic           neg_ff;
   logic [itrs_pkg::STEP_W-1:0] step_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DW-1:0]  rd_data_ff;
   logic           out_valid_ff;
   logic [CW-1:0]  out_char_ff;
   logic           out_last_ff;
   logic           out_bad_ff;

   logic [VW-1:0]  neg_mag;
   logic [DW:0]    rem_sh;
   logic           q_bit;
   logic [DW-1:0]  rem_in;
   logic [CNT_W-1:0] cnt_dec;

   assign neg_mag = VW'(-req_value);

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_sh = {rem_ff, mag_ff[VW-1]};
   assign q_bit  = (rem_sh >= {1'b0, base_ff});
   assign rem_in = q_bit ? DW'(rem_sh - {1'b0, base_ff}) : rem_sh[DW-1:0];

   assign cnt_dec = cnt_ff - CNT_W'(1);

   assign sts.base_bad  = (req_base < itrs_pkg::BASE_MIN) || (req_base > itrs_pkg::BASE_MAX);
   assign sts.step_last = (step_ff == itrs_pkg::STEP_W'(VW - 1));
   assign sts.quot_zero = (mag_ff == '0);
   assign sts.cnt_top   = (cnt_ff == CNT_W'(MAX_DIGITS - 1));
   assign sts.neg       = neg_ff;
   assign sts.idx_last  = (cnt_ff == CNT_W'(1));
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff  <= req_value[VW-1] ? neg_mag : req_value;
         neg_ff  <= req_value[VW-1];
         base_ff <= req_base;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.step) begin
         mag_ff  <= {mag_ff[VW-2:0], q_bit};
         rem_ff  <= rem_in;
         step_ff <= step_ff + itrs_pkg::STEP_W'(1);
      end else if (cmd.store) begin
         rem_ff  <= '0;
         step_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         digit_mem[cnt_ff[IDX_W-1:0]] <= rem_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= digit_mem[cnt_dec[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.store) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end else if (cmd.emit_digit) begin
         cnt_ff <= cnt_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit || cmd.emit_bad) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         out_char_ff <= itrs_pkg::CHAR_MINUS;
         out_last_ff <= 1'b0;
         out_bad_ff  <= 1'b0;
      end else if (cmd.emit_digit) begin
         out_char_ff <= itrs_pkg::digit_to_ascii(rd_data_ff);
         out_last_ff <= sts.idx_last;
         out_bad_ff  <= 1'b0;
      end else if (cmd.emit_bad) begin
         out_char_ff <= itrs_pkg::CHAR_QUEST;
         out_last_ff <= 1'b1;
         out_bad_ff  <= 1'b1;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_bad_base  = out_bad_ff;

endmodule

FILE: sv/integer_to_radix_string_core.sv
// Top level of the integer to radix string core: controller plus datapath.
// Depends on itrs_pkg, itrs_ctrl and itrs_dpath.
//
// Usage:
//  - Request channel (req_*): a 63-bit signed value and a 6-bit base. One
//    request is taken while req_ready is high, i.e. when the previous one is
//    fully converted and all but possibly its final character is handed off.
//  - Response channel (rsp_*): one ASCII character per transfer, most
//    significant first, '-' ahead of a negative value; rsp_last marks the
//    final one. A base outside 2..36 yields a single '?' with rsp_bad_base.
//  - Sequence: each digit is formed on the one-bit-per-cycle restoring
//    divider (63 shift/subtract steps plus a store). Output then takes an
//    output load for '-' and, per digit, a buffer read and an output load.
//    A bad base skips division and loads '?' once the output register is free.
//  - The output register decouples the sides: when the receiver stalls, the
//    current character holds and emission pauses; the next request may be
//    taken while the final character of the previous one is still waiting.
//  - Reset (synchronous, active high) returns the controller to idle, clears
//    the digit count and drops rsp_valid. The digit buffer is not cleared.
module integer_to_radix_string_core #(
   parameter int MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [itrs_pkg::VALUE_W-1:0] req_value,
   input  logic        [itrs_pkg::BASE_W-1:0]  req_base,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [itrs_pkg::CHAR_W-1:0]  rsp_character,
   output logic                                rsp_last,
   output logic                                rsp_bad_base
);

   itrs_pkg::itrs_cmd_type cmd;
   itrs_pkg::itrs_sts_type sts;

   // sequencing: divide, store digit, repeat; then sign and digits in reverse
   itrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // serial divider, digit buffer and output register
   itrs_dpath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_base      (req_base),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_bad_base  (rsp_bad_base),
      .cmd           (cmd),
      .sts           (sts)
   );

endmodule

FILE: verif/tb.sv
// Testbench for integer_to_radix_string_core: a queue-fed request driver, a response
// monitor and a local text predictor. Depends on itrs_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;

   // one expected response character
   typedef struct packed {
      logic [itrs_pkg::CHAR_W-1:0] character;
      logic                        last;
      logic                        bad_base;
   } text_char_type;

   // one request waiting to go out; hold_off makes the driver wait for an empty
   // response backlog before presenting it
   typedef struct packed {
      logic [itrs_pkg::VALUE_W-1:0] value;
      logic [itrs_pkg::BASE_W-1:0]  base;
      logic                         hold_off;
   } conv_req_type;

   localparam logic [itrs_pkg::CHAR_W-1:0]  ASCII_A   = itrs_pkg::CHAR_W'(8'h41);
   localparam logic [itrs_pkg::VALUE_W-1:0] MOST_NEG  =
      {1'b1, {(itrs_pkg::VALUE_W-1){1'b0}}};
   localparam logic [itrs_pkg::VALUE_W-1:0] MOST_POS  =
      {1'b0, {(itrs_pkg::VALUE_W-1){1'b1}}};
   localparam logic [itrs_pkg::VALUE_W-1:0] MINUS_ONE = {itrs_pkg::VALUE_W{1'b1}};
   localparam int IDLE_PCT    = 20;
   localparam int QUIET_START = 20000;   // both sides run flat out in this window
   localparam int QUIET_END   = 45000;
   localparam int DRAIN_WAIT  = 300;     // cycles to watch for strays at the end
   localparam int N_RANDOM    = 78;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [itrs_pkg::VALUE_W-1:0]  req_value = '0;
   logic        [itrs_pkg::BASE_W-1:0]   req_base = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic        [itrs_pkg::CHAR_W-1:0]   rsp_character;
   logic                                 rsp_last;
   logic                                 rsp_bad_base;

   conv_req_type  req_backlog [$];   // requests not yet presented
   text_char_type char_due [$];      // characters predicted, not yet seen
   int            err_count = 0;
   int            cycle_count = 0;
   int            cycle_limit = 0;
   logic          quiet;

   integer_to_radix_string_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_base      (req_base),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_bad_base  (rsp_bad_base)
   );

   always #5 clock = ~clock;

   assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

   // Predictor: digits of the magnitude by repeated division, least significant
   // first, then pushed most significant first behind an optional '-'.
   function automatic void predict_text(input logic [itrs_pkg::VALUE_W-1:0] value,
                                        input logic [itrs_pkg::BASE_W-1:0] base);
      logic [itrs_pkg::VALUE_W-1:0] mag;
      logic [itrs_pkg::DIGIT_W-1:0] digit_buf [0:itrs_pkg::MAX_DIGITS_DEF-1];
      logic [itrs_pkg::DIGIT_W-1:0] d;
      text_char_type                c;
      int                           n;
      // out-of-range base: a lone '?' flagged bad, digit state untouched
      if (base < itrs_pkg::BASE_MIN || base > itrs_pkg::BASE_MAX) begin
         c.character = itrs_pkg::CHAR_QUEST;
         c.last      = 1'b1;
         c.bad_base  = 1'b1;
         char_due.push_back(c);
         return;
      end
      // two's complement magnitude; the most negative value maps to 2^62
      mag = value[itrs_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      n = 0;
      do begin
         digit_buf[n] = itrs_pkg::DIGIT_W'(mag % base);
         n++;
         mag = mag / base;
      end while (mag != 0 && n < itrs_pkg::MAX_DIGITS_DEF);
      if (value[itrs_pkg::VALUE_W-1]) begin
         c.character = itrs_pkg::CHAR_MINUS;
         c.last      = 1'b0;
         c.bad_base  = 1'b0;
         char_due.push_back(c);
      end
      for (int i = n; i > 0; i--) begin
         d = digit_buf[i-1];
         c.character = (d < itrs_pkg::DEC_DIGITS) ?
                       itrs_pkg::CHAR_ZERO + itrs_pkg::CHAR_W'(d) :
                       ASCII_A + itrs_pkg::CHAR_W'(d - itrs_pkg::DEC_DIGITS);
         c.last      = (i == 1);
         c.bad_base  = 1'b0;
         char_due.push_back(c);
      end
   endfunction

   function automatic void add_request(input logic [itrs_pkg::VALUE_W-1:0] value,
                                       input logic [itrs_pkg::BASE_W-1:0] base,
                                       input logic hold_off);
      conv_req_type r;
      r.value    = value;
      r.base     = base;
      r.hold_off = hold_off;
      req_backlog.push_back(r);
   endfunction

   // Request driver. A presented request holds until taken; the prediction is
   // made at the edge where the request is accepted. req_valid gets one
   // assignment per edge at most.
   always @(posedge clock) begin : drive_req
      logic busy;
      logic idle_now;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid && !req_ready;
         idle_now = !quiet && ($urandom_range(99) < IDLE_PCT);
         if (req_valid && req_ready) begin
            predict_text(req_value, req_base);
         end
         if (!busy) begin
            if (req_backlog.size() != 0 && !idle_now &&
                !(req_backlog[0].hold_off && char_due.size() != 0)) begin
               req_valid <= 1'b1;
               req_value <= req_backlog[0].value;
               req_base  <= req_backlog[0].base;
               req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: every accepted character against the oldest prediction.
   always @(posedge clock) begin : watch_rsp
      text_char_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (char_due.size() == 0) begin
               $error("character with no request pending: %h", rsp_character);
               err_count++;
            end else begin
               want = char_due.pop_front();
               if (rsp_character !== want.character) begin
                  $error("character: expected %h, got %h", want.character, rsp_character);
                  err_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_last);
                  err_count++;
               end
               if (rsp_bad_base !== want.bad_base) begin
                  $error("bad_base: expected %b, got %b", want.bad_base, rsp_bad_base);
                  err_count++;
               end
            end
         end
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_limit != 0 && cycle_count >= cycle_limit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [itrs_pkg::VALUE_W-1:0] raw;
      logic [itrs_pkg::BASE_W-1:0]  b;
      int                           k;

      // directed: zero, +/-1, extremes, letter digits, bad bases
      add_request('0, 6'd10, 1'b0);
      add_request('0, 6'd2, 1'b0);
      add_request(63'd1, 6'd36, 1'b0);
      add_request(MINUS_ONE, 6'd10, 1'b0);
      add_request(MOST_POS, 6'd2, 1'b0);
      add_request(MOST_NEG, 6'd2, 1'b0);      // 63 binary digits plus sign
      add_request(MOST_NEG, 6'd36, 1'b0);
      add_request(MOST_NEG, 6'd10, 1'b0);
      add_request(MOST_POS, 6'd36, 1'b0);
      add_request(MOST_POS, 6'd10, 1'b0);
      add_request(63'd35, 6'd36, 1'b0);       // single 'Z'
      add_request(63'd36, 6'd36, 1'b0);       // "10"
      add_request(63'd9, 6'd10, 1'b0);
      add_request(63'd10, 6'd11, 1'b0);       // single 'A'
      add_request(63'hDEAD_BEEF, 6'd16, 1'b0);
      add_request(-63'sd12345, 6'd3, 1'b0);
      add_request(MOST_POS, 6'd32, 1'b0);
      add_request(-63'sd1000, 6'd7, 1'b0);
      add_request(MOST_NEG, 6'd0, 1'b0);
      add_request(MOST_POS, 6'd1, 1'b0);
      add_request(63'd5, 6'd37, 1'b0);
      add_request(MINUS_ONE, 6'd63, 1'b0);

      // random: variable magnitude, either sign, now and then a bad base
      for (k = 0; k < N_RANDOM; k++) begin
         raw = itrs_pkg::VALUE_W'({$urandom, $urandom});
         raw = raw >> $urandom_range(0, itrs_pkg::VALUE_W - 1);
         if ($urandom_range(1)) begin
            raw = ~raw + 1'b1;
         end
         if ($urandom_range(99) < 10) begin
            b = $urandom_range(1) ? itrs_pkg::BASE_W'($urandom_range(1)) :
                                    itrs_pkg::BASE_W'($urandom_range(37, 63));
         end else begin
            b = itrs_pkg::BASE_W'($urandom_range(itrs_pkg::BASE_MIN, itrs_pkg::BASE_MAX));
         end
         // pause for a full drain before the random part and again midway
         add_request(raw, b, (k == 0) || (k == N_RANDOM / 2));
      end

      // worst case per request: 63 binary digits, 64 stalled characters
      cycle_limit = 1000 + req_backlog.size() * 20000;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (char_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
